### sv/g711_sample_mixer_core_macros.svh
// Assertion helpers for the G.711 mixer core.
// Both expect signals named clock and reset in the enclosing scope.
`ifndef G711_SAMPLE_MIXER_CORE_MACROS_SVH
`define G711_SAMPLE_MIXER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define G7MIX_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("g7mix: same-cycle check failed");
`define G7MIX_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("g7mix: next-cycle check failed");
`else
`define G7MIX_ASSERT_NOW(label, ante, cons)
`define G7MIX_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### sv/g7mix_pkg.sv
package g7mix_pkg;

   // companding law codes (out_format)
   localparam logic [1:0] FMT_ALAW = 2'd0;
   localparam logic [1:0] FMT_ULAW = 2'd1;

   // register indexes (byte address bit 2)
   localparam logic REG_OUT_FORMAT = 1'b0;
   localparam logic REG_SILENCE    = 1'b1;

   localparam logic [1:0] OUT_FORMAT_RST = 2'd0;
   localparam logic [7:0] SILENCE_RST    = 8'd213;

   typedef struct packed {
      logic [1:0] out_format;
      logic [7:0] silence_sample;
   } cfg_type;

endpackage

### sv/g7mix_if.sv
interface g7mix_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] base_sample;
   logic [7:0] other_sample;
   logic       other_present;
   logic       last_in_block;

   modport source (output valid, base_sample, other_sample, other_present, last_in_block,
                   input ready);
   modport sink   (input valid, base_sample, other_sample, other_present, last_in_block,
                   output ready);
endinterface

interface g7mix_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] mixed_sample;
   logic       last_out;

   modport source (output valid, mixed_sample, last_out, input ready);
   modport sink   (input valid, mixed_sample, last_out, output ready);
endinterface

### sv/g711_sample_mixer_core.sv
// G.711 sample mixer core.
// Pipeline stages from a req transfer to the rsp result: expand, multiply,
// divide-by-65535, combine, compress, each stage one register.
// Throughput: one sample pair per cycle; a stalled rsp backs up stage by stage.
// Reset (synchronous, active high) empties the pipeline and loads
// out_format = A-law and silence_sample = 0xD5.
`include "g711_sample_mixer_core_macros.svh"

module g711_sample_mixer_core (
   input  logic              clock,
   input  logic              reset,
   g7mix_req_if.sink         req_bus,
   g7mix_rsp_if.source       rsp_bus,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   // |a*b| <= 32256^2, so the quotient never exceeds this
   localparam logic [15:0] QUOT_MAX = 16'd15876;

   // segment end points of the compressors
   localparam logic [13:0] A_SEG_END [8] = '{14'h001F, 14'h003F, 14'h007F, 14'h00FF,
                                             14'h01FF, 14'h03FF, 14'h07FF, 14'h0FFF};
   localparam logic [13:0] U_SEG_END [8] = '{14'h003F, 14'h007F, 14'h00FF, 14'h01FF,
                                             14'h03FF, 14'h07FF, 14'h0FFF, 14'h1FFF};

   // ---------------------------------------------------------------
   // Companding helpers
   // ---------------------------------------------------------------
   function automatic logic signed [15:0] expand_a(input logic [7:0] code);
      logic [7:0]  v;
      logic [2:0]  seg;
      logic [15:0] t;
      v   = code ^ 8'h55;
      seg = v[6:4];
      t   = {8'd0, v[3:0], 4'd0};
      if (seg == 3'd0) begin
         t = t + 16'd8;
      end else if (seg == 3'd1) begin
         t = t + 16'h0108;
      end else begin
         t = (t + 16'h0108) << (seg - 3'd1);
      end
      return v[7] ? $signed(t) : -$signed(t);
   endfunction

   function automatic logic signed [15:0] expand_u(input logic [7:0] code);
      logic [7:0]  v;
      logic [2:0]  seg;
      logic [15:0] t;
      v   = ~code;
      seg = v[6:4];
      t   = ({9'd0, v[3:0], 3'd0} + 16'h0084) << seg;
      return v[7] ? $signed(16'h0084 - t) : $signed(t - 16'h0084);
   endfunction

   function automatic logic [7:0] compress_a(input logic signed [17:0] x);
      logic [14:0] sel;
      logic [13:0] mag;
      logic [3:0]  seg;
      logic [13:0] shifted;
      logic [7:0]  mask;
      logic [7:0]  code;
      // negative side: floor(x/8) negated minus one == (~x) >> 3
      sel  = x[17] ? ~x[17:3] : x[17:3];
      mag  = sel[13:0];
      mask = x[17] ? 8'h55 : 8'hD5;
      seg  = 4'd8;
      for (int s = 7; s >= 0; s--) begin
         if (mag <= A_SEG_END[s]) seg = 4'(s);
      end
      if (seg[3]) begin
         code = 8'h7F;
      end else begin
         shifted = (seg < 4'd2) ? (mag >> 1) : (mag >> seg);
         code    = {1'b0, seg[2:0], shifted[3:0]};
      end
      return code ^ mask;
   endfunction

   function automatic logic [7:0] compress_u(input logic signed [17:0] x);
      logic [18:0] nx;
      logic [16:0] m;
      logic [13:0] mag;
      logic [3:0]  seg;
      logic [13:0] shifted;
      logic [7:0]  mask;
      logic [7:0]  code;
      // negative side: ceil(-x/4)
      nx   = 19'(-{x[17], x}) + 19'd3;
      m    = x[17] ? nx[18:2] : {1'b0, x[17:2]};
      mask = x[17] ? 8'h7F : 8'hFF;
      if (m > 17'd8159) m = 17'd8159;
      mag = m[13:0] + 14'd33;
      seg = 4'd8;
      for (int s = 7; s >= 0; s--) begin
         if (mag <= U_SEG_END[s]) seg = 4'(s);
      end
      if (seg[3]) begin
         code = 8'h7F;
      end else begin
         shifted = mag >> (seg + 4'd1);
         code    = {1'b0, seg[2:0], shifted[3:0]};
      end
      return code ^ mask;
   endfunction

   // ---------------------------------------------------------------
   // Config registers
   // ---------------------------------------------------------------
   g7mix_pkg::cfg_type cfg;

   g7mix_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // ---------------------------------------------------------------
   // Pipeline control: a stage loads when it is empty or the stage
   // after it loads too. Stage 5 is the output register.
   // ---------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic ld1, ld2, ld3, ld4, ld5;

   assign ld5 = !s5_valid_ff || rsp_bus.ready;
   assign ld4 = !s4_valid_ff || ld5;
   assign ld3 = !s3_valid_ff || ld4;
   assign ld2 = !s2_valid_ff || ld3;
   assign ld1 = !s1_valid_ff || ld2;

   assign req_bus.ready = ld1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (ld1) s1_valid_ff <= req_bus.valid;
         if (ld2) s2_valid_ff <= s1_valid_ff;
         if (ld3) s3_valid_ff <= s2_valid_ff;
         if (ld4) s4_valid_ff <= s3_valid_ff;
         if (ld5) s5_valid_ff <= s4_valid_ff;
      end
   end

   // sideband that rides with every item: law, base byte, block flag
   logic [1:0] s1_fmt_ff, s2_fmt_ff, s3_fmt_ff, s4_fmt_ff;
   logic [7:0] s1_base_ff, s2_base_ff, s3_base_ff, s4_base_ff;
   logic       s1_last_ff, s2_last_ff, s3_last_ff, s4_last_ff;

   // ---------------------------------------------------------------
   // Stage 1: pick the second byte (or silence), expand both to linear.
   // ---------------------------------------------------------------
   logic [7:0]         other_sel;
   logic signed [15:0] lin_other_in, lin_base_in;
   logic signed [15:0] s1_lin_other_ff, s1_lin_base_ff;

   assign other_sel = req_bus.other_present ? req_bus.other_sample : cfg.silence_sample;

   always_comb begin
      if (cfg.out_format == g7mix_pkg::FMT_ULAW) begin
         lin_other_in = expand_u(other_sel);
         lin_base_in  = expand_u(req_bus.base_sample);
      end else begin
         lin_other_in = expand_a(other_sel);
         lin_base_in  = expand_a(req_bus.base_sample);
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_lin_other_ff <= lin_other_in;
         s1_lin_base_ff  <= lin_base_in;
         s1_fmt_ff       <= cfg.out_format;
         s1_base_ff      <= req_bus.base_sample;
         s1_last_ff      <= req_bus.last_in_block;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: product and sum of the two linear values.
   // ---------------------------------------------------------------
   logic signed [31:0] s2_prod_ff;
   logic signed [16:0] s2_sum_ff;

   always_ff @(posedge clock) begin
      if (ld2) begin
         s2_prod_ff <= s1_lin_other_ff * s1_lin_base_ff;
         s2_sum_ff  <= 17'(s1_lin_other_ff) + 17'(s1_lin_base_ff);
         s2_fmt_ff  <= s1_fmt_ff;
         s2_base_ff <= s1_base_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: |prod| / 65535 truncated. With n = h*2^16 + l,
   // n = h*65535 + (h + l) and h + l < 2*65535, so one compare fixes it.
   // ---------------------------------------------------------------
   logic [31:0] prod_mag;
   logic [16:0] part_sum;
   logic [15:0] quot_in;
   logic [15:0] s3_quot_ff;
   logic        s3_neg_ff;
   logic signed [16:0] s3_sum_ff;

   assign prod_mag = s2_prod_ff[31] ? 32'(-s2_prod_ff) : 32'(s2_prod_ff);
   assign part_sum = {1'b0, prod_mag[31:16]} + {1'b0, prod_mag[15:0]};
   assign quot_in  = prod_mag[31:16] + {15'd0, (part_sum >= 17'd65535)};

   always_ff @(posedge clock) begin
      if (ld3) begin
         s3_quot_ff <= quot_in;
         s3_neg_ff  <= s2_prod_ff[31];
         s3_sum_ff  <= s2_sum_ff;
         s3_fmt_ff  <= s2_fmt_ff;
         s3_base_ff <= s2_base_ff;
         s3_last_ff <= s2_last_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: mix = a + b - a*b/65535.
   // ---------------------------------------------------------------
   logic signed [17:0] mix_in;
   logic signed [17:0] s4_mix_ff;

   assign mix_in = s3_neg_ff ? 18'(s3_sum_ff) + $signed({2'b00, s3_quot_ff})
                             : 18'(s3_sum_ff) - $signed({2'b00, s3_quot_ff});

   always_ff @(posedge clock) begin
      if (ld4) begin
         s4_mix_ff  <= mix_in;
         s4_fmt_ff  <= s3_fmt_ff;
         s4_base_ff <= s3_base_ff;
         s4_last_ff <= s3_last_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 5: compress back by the same law; other codes pass base.
   // ---------------------------------------------------------------
   logic [7:0] code_in;
   logic [7:0] s5_code_ff;
   logic       s5_last_ff;

   always_comb begin
      unique case (s4_fmt_ff)
         g7mix_pkg::FMT_ALAW: code_in = compress_a(s4_mix_ff);
         g7mix_pkg::FMT_ULAW: code_in = compress_u(s4_mix_ff);
         default:             code_in = s4_base_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ld5) begin
         s5_code_ff <= code_in;
         s5_last_ff <= s4_last_ff;
      end
   end

   assign rsp_bus.valid        = s5_valid_ff;
   assign rsp_bus.mixed_sample = s5_code_ff;
   assign rsp_bus.last_out     = s5_last_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   // an empty output register means the whole chain can move
   `G7MIX_ASSERT_NOW(a_ready_when_out_empty, !s5_valid_ff, req_bus.ready)
   // a transfer lands in stage 1
   `G7MIX_ASSERT_NEXT(a_accept_fills_s1, req_bus.valid && req_bus.ready, s1_valid_ff)
   // an item moving out of stage 4 lands in the output register
   `G7MIX_ASSERT_NEXT(a_s4_moves_to_out, s4_valid_ff && ld5, s5_valid_ff)
   // divider correction never overshoots the product bound
   `G7MIX_ASSERT_NOW(a_quot_range, s3_valid_ff, s3_quot_ff <= QUOT_MAX)

endmodule

### sv/g7mix_csr.sv
module g7mix_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output g7mix_pkg::cfg_type   cfg
);

   logic [1:0] format_ff, format_in;
   logic [7:0] silence_ff, silence_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      format_in  = format_ff;
      silence_in = silence_ff;
      if (wr_en) begin
         unique case (paddr[2])
            g7mix_pkg::REG_OUT_FORMAT: format_in  = pwdata[1:0];
            g7mix_pkg::REG_SILENCE:    silence_in = pwdata[7:0];
            default:                   format_in  = format_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff  <= g7mix_pkg::OUT_FORMAT_RST;
         silence_ff <= g7mix_pkg::SILENCE_RST;
      end else begin
         format_ff  <= format_in;
         silence_ff <= silence_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         g7mix_pkg::REG_OUT_FORMAT: prdata = {30'd0, format_ff};
         g7mix_pkg::REG_SILENCE:    prdata = {24'd0, silence_ff};
         default:                   prdata = 32'd0;
      endcase
   end

   assign cfg.out_format     = format_ff;
   assign cfg.silence_sample = silence_ff;

endmodule
